FILE: rtl/core/gcms_pkg.sv
// Shared constants, codes and types of the circular genome motif scanner.
`timescale 1ns / 1ps
package gcms_pkg;

	localparam int GENOME_MAX     = 4096;
	localparam int ADDR_W         = $clog2(GENOME_MAX);
	localparam int LEN_W          = 13;

	localparam int PROMOTER_LEN   = 22;
	localparam int STEM_LEN       = 4;
	localparam int TERMINATOR_LEN = 11;
	localparam int START_LEN      = 13;
	localparam int STOP_LEN       = 3;
	localparam int CODON_LEN      = 3;

	// The read window covers the longest motif.
	localparam int WIN_A   = (PROMOTER_LEN > TERMINATOR_LEN) ? PROMOTER_LEN : TERMINATOR_LEN;
	localparam int WIN_B   = (START_LEN > STOP_LEN) ? START_LEN : STOP_LEN;
	localparam int WIN_C   = (WIN_B > CODON_LEN) ? WIN_B : CODON_LEN;
	localparam int WIN_LEN = (WIN_A > WIN_C) ? WIN_A : WIN_C;
	localparam int K_W     = $clog2(WIN_LEN);

	localparam int START_IDX_W = $clog2(START_LEN);
	localparam int STOP_IDX_W  = $clog2(STOP_LEN);

	localparam int OP_W         = 2;
	localparam int PROMOTER_W   = 22;
	localparam int START_W      = 13;
	localparam int STOP_W       = 3;
	localparam int PROM_DIST_W  = 5;
	localparam int TERM_DIST_W  = 3;
	localparam int CODON_W      = 3;

	localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
	localparam logic [OP_W-1:0] OP_FLIP  = 2'd1;
	localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 22;
	localparam logic [CFG_IDX_W-1:0] CFG_GENOME_LENGTH    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PROMOTER_PATTERN = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_START_PATTERN    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_START_CARE_MASK  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_STOP_PATTERN     = 3'd4;

	localparam logic [LEN_W-1:0]   RST_GENOME_LENGTH   = 13'd4096;
	localparam logic [START_W-1:0] RST_START_CARE_MASK = 13'd6271;

	// Read-back of one genome bit, arriving in the cycle after its address.
	typedef struct packed {
		logic           clear;
		logic           valid;
		logic [K_W-1:0] k;
	} rd_ctl_t;

	typedef struct packed {
		logic commit;
		logic pos_err;
	} fin_t;

	typedef struct packed {
		logic [PROM_DIST_W-1:0] promoter_distance;
		logic [TERM_DIST_W-1:0] terminator_distance;
		logic                   start_found;
		logic                   stop_found;
		logic [CODON_W-1:0]     codon_value;
	} motif_res_t;

endpackage

FILE: rtl/core/gcms_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module gcms_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: rtl/core/gcms_ctrl.sv
// Sequencer: store writes, read-modify-write flips and the wrapped query read walk.
`timescale 1ns / 1ps
module gcms_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [gcms_pkg::OP_W-1:0]     op,
	input  logic [gcms_pkg::ADDR_W-1:0]   position,
	input  logic                          base_value,
	input  logic [gcms_pkg::LEN_W-1:0]    eff_len,
	input  logic                          out_busy,
	output logic                          ram_we,
	output logic [gcms_pkg::ADDR_W-1:0]   ram_waddr,
	output logic                          ram_wdata,
	output logic                          ram_re,
	output logic [gcms_pkg::ADDR_W-1:0]   ram_raddr,
	input  logic                          ram_rdata,
	output gcms_pkg::rd_ctl_t             rd_ctl,
	output gcms_pkg::fin_t                fin
);
	import gcms_pkg::*;

	localparam logic [2:0] S_IDLE    = 3'd0;
	localparam logic [2:0] S_FLIP_WR = 3'd1;
	localparam logic [2:0] S_QRY     = 3'd2;
	localparam logic [2:0] S_DRAIN   = 3'd3;
	localparam logic [2:0] S_FINISH  = 3'd4;

	logic [2:0]        state_q;
	logic [ADDR_W-1:0] addr_q;
	logic [K_W-1:0]    cnt_q;
	logic              err_q;
	logic              rd_valid_s1;
	logic [K_W-1:0]    rd_k_s1;
	logic              accept;
	logic              pos_err;
	logic [LEN_W-1:0]  addr_inc;
	logic [ADDR_W-1:0] addr_next;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign pos_err  = (LEN_W'(position) >= eff_len);

	// The walk wraps at the effective length, so short genomes wrap repeatedly.
	assign addr_inc  = LEN_W'(addr_q) + LEN_W'(1);
	assign addr_next = (addr_inc == eff_len) ? '0 : addr_inc[ADDR_W-1:0];

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = position;
		ram_wdata = base_value;
		if (accept && (op == OP_WRITE)) begin
			ram_we = 1'b1;
		end else if (state_q == S_FLIP_WR) begin
			ram_we    = 1'b1;
			ram_waddr = addr_q;
			ram_wdata = ~ram_rdata;
		end
	end

	assign ram_re    = (accept && (op == OP_FLIP)) || (state_q == S_QRY);
	assign ram_raddr = (state_q == S_QRY) ? addr_q : position;

	assign rd_ctl.clear = accept && (op == OP_QUERY);
	assign rd_ctl.valid = rd_valid_s1;
	assign rd_ctl.k     = rd_k_s1;

	assign fin.commit  = (state_q == S_FINISH) && !out_busy;
	assign fin.pos_err = err_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rd_valid_s1 <= 1'b0;
			cnt_q       <= '0;
			err_q       <= 1'b0;
		end else begin
			rd_valid_s1 <= (state_q == S_QRY);
			unique case (state_q)
				S_IDLE: begin
					if (accept && (op == OP_FLIP)) begin
						state_q <= S_FLIP_WR;
					end else if (accept && (op == OP_QUERY)) begin
						err_q   <= pos_err;
						cnt_q   <= '0;
						state_q <= pos_err ? S_FINISH : S_QRY;
					end
				end
				S_FLIP_WR: begin
					state_q <= S_IDLE;
				end
				S_QRY: begin
					cnt_q <= cnt_q + K_W'(1);
					if (cnt_q == K_W'(WIN_LEN - 1)) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					state_q <= S_FINISH;
				end
				S_FINISH: begin
					if (!out_busy) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		rd_k_s1 <= cnt_q;
		if (accept) begin
			addr_q <= position;
		end else if (state_q == S_QRY) begin
			addr_q <= addr_next;
		end
	end

endmodule

FILE: rtl/core/gcms_eval.sv
// Motif evaluator: folds each returned genome bit into the running match results.
`timescale 1ns / 1ps
module gcms_eval (
	input  logic                              clk,
	input  gcms_pkg::rd_ctl_t                 rd_ctl,
	input  logic                              bit_in,
	input  logic [gcms_pkg::PROMOTER_W-1:0]   promoter_pattern,
	input  logic [gcms_pkg::START_W-1:0]      start_pattern,
	input  logic [gcms_pkg::START_W-1:0]      start_care_mask,
	input  logic [gcms_pkg::STOP_W-1:0]       stop_pattern,
	output gcms_pkg::motif_res_t              res
);
	import gcms_pkg::*;

	logic [WIN_LEN-1:0]     win_q;
	logic [PROM_DIST_W-1:0] prom_q;
	logic [TERM_DIST_W-1:0] term_q;
	logic                   start_q;
	logic                   stop_q;
	logic [CODON_W-1:0]     codon_q;
	logic [K_W-1:0]         k;
	logic [K_W-1:0]         mirror_k;

	assign k        = rd_ctl.k;
	assign mirror_k = K_W'(TERMINATOR_LEN - 1) - k;

	always_ff @(posedge clk) begin
		if (rd_ctl.clear) begin
			prom_q  <= '0;
			term_q  <= '0;
			start_q <= 1'b1;
			stop_q  <= 1'b1;
			codon_q <= '0;
		end else if (rd_ctl.valid) begin
			win_q[k] <= bit_in;
			if (k < K_W'(PROMOTER_LEN)) begin
				prom_q <= prom_q + PROM_DIST_W'(bit_in ^ promoter_pattern[k]);
			end
			// The far end of each stem pair arrives after its partner is stored.
			if ((k >= K_W'(TERMINATOR_LEN - STEM_LEN)) && (k <= K_W'(TERMINATOR_LEN - 1))) begin
				term_q <= term_q + TERM_DIST_W'(bit_in ^ win_q[mirror_k]);
			end
			if (k < K_W'(START_LEN)) begin
				if (start_care_mask[k[START_IDX_W-1:0]] &&
				    (bit_in != start_pattern[k[START_IDX_W-1:0]])) begin
					start_q <= 1'b0;
				end
			end
			if (k < K_W'(STOP_LEN)) begin
				if (bit_in != stop_pattern[k[STOP_IDX_W-1:0]]) begin
					stop_q <= 1'b0;
				end
			end
			if (k < K_W'(CODON_LEN)) begin
				codon_q <= {codon_q[CODON_W-2:0], bit_in};
			end
		end
	end

	assign res.promoter_distance   = prom_q;
	assign res.terminator_distance = term_q;
	assign res.start_found         = start_q;
	assign res.stop_found          = stop_q;
	assign res.codon_value         = codon_q;

endmodule

FILE: rtl/core/circular_genome_motif_scanner_top.sv
// Top level of the circular genome motif scanner: registers, genome store and result register.
// A write goes straight to the store; a flip reads the base, then writes it back inverted;
// in_ready is low while a flip or query runs. A query reads its 22 wrapped bases one per
// cycle from the single-bit store read port, then passes drain and finish states; it commits
// the result once the output register is free. An out-of-range query goes straight to finish.
// A finished result waits in the output register while writes and flips go on.
// Reset clears control state and loads the register reset values; the store is not cleared.
`timescale 1ns / 1ps
module circular_genome_motif_scanner_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [gcms_pkg::OP_W-1:0]           op,
	input  logic [gcms_pkg::ADDR_W-1:0]         position,
	input  logic                                base_value,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [gcms_pkg::PROM_DIST_W-1:0]    promoter_distance,
	output logic [gcms_pkg::TERM_DIST_W-1:0]    terminator_distance,
	output logic                                start_found,
	output logic                                stop_found,
	output logic [gcms_pkg::CODON_W-1:0]        codon_value,
	output logic                                position_error,
	input  logic                                cfg_we,
	input  logic [gcms_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [gcms_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
	import gcms_pkg::*;

	logic [LEN_W-1:0]      genome_length_q;
	logic [PROMOTER_W-1:0] promoter_pattern_q;
	logic [START_W-1:0]    start_pattern_q;
	logic [START_W-1:0]    start_care_mask_q;
	logic [STOP_W-1:0]     stop_pattern_q;
	logic [LEN_W-1:0]      eff_len;

	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic              ram_wdata;
	logic              ram_re;
	logic [ADDR_W-1:0] ram_raddr;
	logic              ram_rdata;
	rd_ctl_t           rd_ctl;
	fin_t              fin;
	motif_res_t        res;

	logic       out_valid_q;
	motif_res_t res_q;
	logic       err_q;

	assign eff_len = (genome_length_q > LEN_W'(GENOME_MAX)) ? LEN_W'(GENOME_MAX) : genome_length_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			genome_length_q    <= RST_GENOME_LENGTH;
			promoter_pattern_q <= '0;
			start_pattern_q    <= '0;
			start_care_mask_q  <= RST_START_CARE_MASK;
			stop_pattern_q     <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_GENOME_LENGTH:    genome_length_q    <= cfg_wdata[LEN_W-1:0];
				CFG_PROMOTER_PATTERN: promoter_pattern_q <= cfg_wdata[PROMOTER_W-1:0];
				CFG_START_PATTERN:    start_pattern_q    <= cfg_wdata[START_W-1:0];
				CFG_START_CARE_MASK:  start_care_mask_q  <= cfg_wdata[START_W-1:0];
				CFG_STOP_PATTERN:     stop_pattern_q     <= cfg_wdata[STOP_W-1:0];
				default: ;
			endcase
		end
	end

	gcms_ram #(
		.WIDTH(1),
		.DEPTH(GENOME_MAX)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	gcms_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.op        (op),
		.position  (position),
		.base_value(base_value),
		.eff_len   (eff_len),
		.out_busy  (out_valid_q && !out_ready),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata),
		.rd_ctl    (rd_ctl),
		.fin       (fin)
	);

	gcms_eval u_eval (
		.clk             (clk),
		.rd_ctl          (rd_ctl),
		.bit_in          (ram_rdata),
		.promoter_pattern(promoter_pattern_q),
		.start_pattern   (start_pattern_q),
		.start_care_mask (start_care_mask_q),
		.stop_pattern    (stop_pattern_q),
		.res             (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin.commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// An out-of-range query reports the flag alone.
	always_ff @(posedge clk) begin
		if (fin.commit) begin
			res_q <= fin.pos_err ? '0 : res;
			err_q <= fin.pos_err;
		end
	end

	assign out_valid           = out_valid_q;
	assign promoter_distance   = res_q.promoter_distance;
	assign terminator_distance = res_q.terminator_distance;
	assign start_found         = res_q.start_found;
	assign stop_found          = res_q.stop_found;
	assign codon_value         = res_q.codon_value;
	assign position_error      = err_q;

endmodule

FILE: rtl/core/gcms_checker.sv
// Port-level checker for the circular genome motif scanner, bound to the top level.
`timescale 1ns / 1ps
module gcms_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	input  logic                                in_ready,
	input  logic [gcms_pkg::OP_W-1:0]           op,
	input  logic                                out_valid,
	input  logic                                out_ready,
	input  logic [gcms_pkg::PROM_DIST_W-1:0]    promoter_distance,
	input  logic [gcms_pkg::TERM_DIST_W-1:0]    terminator_distance,
	input  logic                                start_found,
	input  logic                                stop_found,
	input  logic [gcms_pkg::CODON_W-1:0]        codon_value,
	input  logic                                position_error
);
	import gcms_pkg::*;

	// A stalled result holds still.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(promoter_distance)
			&& $stable(terminator_distance) && $stable(codon_value)
			&& $stable(position_error))
		else $error("stalled result changed");

	// An out-of-range query carries only the flag.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && position_error |-> promoter_distance == '0
			&& terminator_distance == '0 && !start_found && !stop_found
			&& codon_value == '0)
		else $error("position error result carries motif data");

	// Distances never exceed the promoter length and the stem length.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> promoter_distance <= PROM_DIST_W'(PROMOTER_LEN)
			&& terminator_distance <= TERM_DIST_W'(STEM_LEN))
		else $error("motif distance out of range");

	// A query transfer occupies the sequencer.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && op == OP_QUERY |=> !in_ready)
		else $error("ready right after a query transfer");

	// A write completes in its own cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && op == OP_WRITE |=> in_ready)
		else $error("not ready after a write transfer");

endmodule

bind circular_genome_motif_scanner_top gcms_checker u_gcms_checker (.*);
